// ===== design/mmpd_pkg.sv =====
`default_nettype none

package mmpd_pkg;

  // Default build widths
  localparam int TIME_BITS       = 48;
  localparam int VALUE_BITS      = 32;
  localparam int SCALE_FRAC_BITS = 16;

  // Fixed widths of the scale registers, pixel fields and the magnitude datapath
  localparam int SCALE_W = 32;
  localparam int PIX_W   = 16;
  localparam int MAG_W   = 64;
  localparam int PROD_W  = 64;
  localparam int WHOLE_W = 41;

  // Scaled magnitudes clamp here, far beyond any 16-bit pixel
  localparam logic [WHOLE_W-1:0] MAG_LIMIT = {1'b1, {(WHOLE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    CFG_TIME_ORIGIN  = 3'd0,
    CFG_BUCKET_STEP  = 3'd1,
    CFG_X_SCALE      = 3'd2,
    CFG_X_OFFSET     = 3'd3,
    CFG_VALUE_CENTER = 3'd4,
    CFG_Y_SCALE      = 3'd5,
    CFG_Y_BASE       = 3'd6
  } cfg_idx_e;

  // Integer part and sticky fraction of one scaled magnitude
  typedef struct packed {
    logic [WHOLE_W-1:0] whole;
    logic               frac;
  } scaled_t;

endpackage

`default_nettype wire

// ===== design/minmax_plot_decimator.sv =====
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in       sink       in_valid_i / in_ready_o    sample_time_i, sample_value_i, series_end_i
// out      source     out_valid_o / out_ready_i  column_x_o, y_top_o, y_bottom_o,
//                                                final_column_o
// cfg      sink       cfg_we_i (no wait)         cfg_index_i, cfg_data_i
//
// One sample is taken every cycle while in_ready_o is high. A column passes through
// stages B, C, D and E to the output register once its closing sample leaves stage A;
// the depth is set by the split 32x32 partial products and the clamp/saturate steps.
// Reset clears all valid bits, the bucket state and the registers to their defaults.
// A stalled output backs up stage by stage; bubbles collapse, so in_ready_o stays high
// while any stage ahead is empty.

module minmax_plot_decimator #(
  parameter int TIME_BITS       = mmpd_pkg::TIME_BITS,
  parameter int VALUE_BITS      = mmpd_pkg::VALUE_BITS,
  parameter int SCALE_FRAC_BITS = mmpd_pkg::SCALE_FRAC_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,

  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic [TIME_BITS-1:0]         sample_time_i,
  input  wire logic signed [VALUE_BITS-1:0] sample_value_i,
  input  wire logic                         series_end_i,

  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic signed [15:0]           column_x_o,
  output      logic signed [15:0]           y_top_o,
  output      logic signed [15:0]           y_bottom_o,
  output      logic                         final_column_o,

  input  wire logic                         cfg_we_i,
  input  wire logic [2:0]                   cfg_index_i,
  input  wire logic [((TIME_BITS > VALUE_BITS) ? TIME_BITS : VALUE_BITS)-1:0] cfg_data_i
);

  localparam int SW       = mmpd_pkg::SCALE_W;
  localparam int PW       = mmpd_pkg::PIX_W;
  localparam int MW       = mmpd_pkg::MAG_W;
  localparam int QW       = mmpd_pkg::PROD_W;
  localparam int WW       = mmpd_pkg::WHOLE_W;
  localparam int HALF     = MW / 2;
  localparam int TB1      = TIME_BITS + 1;
  localparam int VB1      = VALUE_BITS + 1;
  localparam int HI_SHIFT = SCALE_FRAC_BITS == 0 ? 32 : 32 - SCALE_FRAC_BITS;
  localparam int HI_KEEP  = 24;
  localparam int SUM_W    = 58;
  localparam int TW       = 43;
  localparam logic [QW-1:0] FRAC_MASK = QW'((64'd1 << SCALE_FRAC_BITS) - 64'd1);
  localparam logic [SW-1:0] ONE_Q     = SW'(64'd1 << SCALE_FRAC_BITS);
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // ---------------------------------------------------------------------------
  // Helpers

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [SW-1:0] b);
    logic [TB1-1:0] s;
    s = {1'b0, a} + TB1'(b);
    sat_add = s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
  endfunction

  function automatic mmpd_pkg::scaled_t split_scale(input logic [QW-1:0] lo,
                                                    input logic [QW-1:0] hi);
    mmpd_pkg::scaled_t r;
    logic [SUM_W-1:0]  sum;
    logic [QW-1:0]     hi_sh;
    logic [QW-1:0]     lo_sh;
    hi_sh = hi << HI_SHIFT;
    lo_sh = lo >> SCALE_FRAC_BITS;
    sum   = SUM_W'(hi_sh) + SUM_W'(lo_sh);
    if (|hi[QW-1:HI_KEEP]) begin
      r.whole = mmpd_pkg::MAG_LIMIT;
      r.frac  = 1'b0;
    end else begin
      r.whole = (sum > SUM_W'(mmpd_pkg::MAG_LIMIT)) ? mmpd_pkg::MAG_LIMIT : sum[WW-1:0];
      r.frac  = |(lo & FRAC_MASK);
    end
    split_scale = r;
  endfunction

  // base +/- whole, truncated toward zero, saturated to 16 bits
  function automatic logic signed [PW-1:0] to_pixel(input mmpd_pkg::scaled_t s,
                                                    input logic neg,
                                                    input logic signed [PW-1:0] base);
    logic signed [TW-1:0] b;
    logic signed [TW-1:0] w;
    logic signed [TW-1:0] t;
    b = {{(TW-PW){base[PW-1]}}, base};
    w = {{(TW-WW){1'b0}}, s.whole};
    t = neg ? b - w : b + w;
    if (!neg && t < 0 && s.frac) begin
      t = t + TW'(1);
    end else if (neg && t > 0 && s.frac) begin
      t = t - TW'(1);
    end
    if (t > TW'(32767)) begin
      to_pixel = 16'sh7fff;
    end else if (t < -TW'(32768)) begin
      to_pixel = 16'sh8000;
    end else begin
      to_pixel = t[PW-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers

  logic [TIME_BITS-1:0]         time_origin_q;
  logic [SW-1:0]                bucket_step_q;
  logic [SW-1:0]                x_scale_q;
  logic signed [PW-1:0]         x_offset_q;
  logic signed [VALUE_BITS-1:0] value_center_q;
  logic [SW-1:0]                y_scale_q;
  logic signed [PW-1:0]         y_base_q;
  logic [TIME_BITS-1:0]         first_end_q;   // time_origin + bucket_step, saturated

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_origin_q  <= '0;
      bucket_step_q  <= SW'(1);
      x_scale_q      <= ONE_Q;
      x_offset_q     <= '0;
      value_center_q <= '0;
      y_scale_q      <= ONE_Q;
      y_base_q       <= '0;
      first_end_q    <= TIME_BITS'(1);
    end else if (cfg_we_i) begin
      case (mmpd_pkg::cfg_idx_e'(cfg_index_i))
        mmpd_pkg::CFG_TIME_ORIGIN: begin
          time_origin_q <= cfg_data_i[TIME_BITS-1:0];
          first_end_q   <= sat_add(cfg_data_i[TIME_BITS-1:0], bucket_step_q);
        end
        mmpd_pkg::CFG_BUCKET_STEP: begin
          bucket_step_q <= cfg_data_i[SW-1:0];
          first_end_q   <= sat_add(time_origin_q, cfg_data_i[SW-1:0]);
        end
        mmpd_pkg::CFG_X_SCALE:      x_scale_q      <= cfg_data_i[SW-1:0];
        mmpd_pkg::CFG_X_OFFSET:     x_offset_q     <= cfg_data_i[PW-1:0];
        mmpd_pkg::CFG_VALUE_CENTER: value_center_q <= cfg_data_i[VALUE_BITS-1:0];
        mmpd_pkg::CFG_Y_SCALE:      y_scale_q      <= cfg_data_i[SW-1:0];
        mmpd_pkg::CFG_Y_BASE:       y_base_q       <= cfg_data_i[PW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage flow control: a stage loads when empty or when it drains this cycle

  logic a_v_q, b_v_q, c_v_q, d_v_q, e_v_q, o_v_q;
  logic ld_a, ld_b, ld_c, ld_d, ld_e, ld_o;

  assign ld_o = !o_v_q || out_ready_i;
  assign ld_e = !e_v_q || ld_o;
  assign ld_d = !d_v_q || ld_e;
  assign ld_c = !c_v_q || ld_d;
  assign ld_b = !b_v_q || ld_c;
  assign ld_a = !a_v_q || ld_b;

  assign in_ready_o  = ld_a;
  assign out_valid_o = o_v_q;

  // ---------------------------------------------------------------------------
  // Stage A: input register and bucket tracking

  logic [TIME_BITS-1:0]         a_time_q;
  logic signed [VALUE_BITS-1:0] a_value_q;
  logic                         a_last_q;

  logic [TIME_BITS-1:0]         bucket_end_q;
  logic signed [VALUE_BITS-1:0] bucket_max_q;
  logic signed [VALUE_BITS-1:0] bucket_min_q;
  logic                         bucket_empty_q;
  logic                         series_open_q;

  logic [TIME_BITS-1:0]         end_eff;
  logic                         empty_eff;
  logic signed [VALUE_BITS-1:0] max_d;
  logic signed [VALUE_BITS-1:0] min_d;
  logic                         emit;
  logic                         a_fire;

  always_comb begin
    end_eff   = series_open_q ? bucket_end_q : first_end_q;
    empty_eff = !series_open_q || bucket_empty_q;
    if (empty_eff) begin
      max_d = a_value_q;
      min_d = a_value_q;
    end else begin
      max_d = (a_value_q > bucket_max_q) ? a_value_q : bucket_max_q;
      min_d = (a_value_q < bucket_min_q) ? a_value_q : bucket_min_q;
    end
    emit   = (a_time_q >= end_eff) || a_last_q;
    a_fire = a_v_q && ld_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (ld_a) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_a && in_valid_i) begin
      a_time_q  <= sample_time_i;
      a_value_q <= sample_value_i;
      a_last_q  <= series_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_end_q   <= '0;
      bucket_max_q   <= '0;
      bucket_min_q   <= '0;
      bucket_empty_q <= 1'b1;
      series_open_q  <= 1'b0;
    end else if (a_fire) begin
      bucket_max_q <= max_d;
      bucket_min_q <= min_d;
      if (emit) begin
        bucket_empty_q <= 1'b1;
        bucket_end_q   <= sat_add(end_eff, bucket_step_q);
        series_open_q  <= !a_last_q;
      end else begin
        bucket_empty_q <= 1'b0;
        bucket_end_q   <= end_eff;
        series_open_q  <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: offsets from origin and value center

  logic [TIME_BITS-1:0]         b_time_q;
  logic signed [VALUE_BITS-1:0] b_max_q;
  logic signed [VALUE_BITS-1:0] b_min_q;
  logic                         b_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (ld_b) begin
      b_v_q <= a_v_q && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire && emit) begin
      b_time_q <= a_time_q;
      b_max_q  <= max_d;
      b_min_q  <= min_d;
      b_last_q <= a_last_q;
    end
  end

  logic                  bx_neg;
  logic [TIME_BITS-1:0]  bx_mag;
  logic signed [VB1-1:0] bt_diff, bb_diff;
  logic [VB1-1:0]        bt_mag, bb_mag;

  always_comb begin
    bx_neg  = b_time_q < time_origin_q;
    bx_mag  = bx_neg ? time_origin_q - b_time_q : b_time_q - time_origin_q;
    bt_diff = {value_center_q[VALUE_BITS-1], value_center_q}
            - {b_max_q[VALUE_BITS-1], b_max_q};
    bb_diff = {value_center_q[VALUE_BITS-1], value_center_q}
            - {b_min_q[VALUE_BITS-1], b_min_q};
    bt_mag  = bt_diff[VB1-1] ? VB1'(-bt_diff) : VB1'(bt_diff);
    bb_mag  = bb_diff[VB1-1] ? VB1'(-bb_diff) : VB1'(bb_diff);
  end

  // ---------------------------------------------------------------------------
  // Stage C: magnitudes, split into 32-bit halves for the multipliers

  logic [MW-1:0] c_x_mag_q, c_t_mag_q, c_b_mag_q;
  logic          c_x_neg_q, c_t_neg_q, c_b_neg_q;
  logic          c_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (ld_c) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_c && b_v_q) begin
      c_x_mag_q <= MW'(bx_mag);
      c_t_mag_q <= MW'(bt_mag);
      c_b_mag_q <= MW'(bb_mag);
      c_x_neg_q <= bx_neg;
      c_t_neg_q <= bt_diff[VB1-1];
      c_b_neg_q <= bb_diff[VB1-1];
      c_last_q  <= b_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: partial products, 32x32 each

  logic [QW-1:0] d_x_lo_q, d_x_hi_q, d_t_lo_q, d_t_hi_q, d_b_lo_q, d_b_hi_q;
  logic          d_x_neg_q, d_t_neg_q, d_b_neg_q;
  logic          d_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (ld_d) begin
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_d && c_v_q) begin
      d_x_lo_q  <= c_x_mag_q[HALF-1:0]  * x_scale_q;
      d_x_hi_q  <= c_x_mag_q[MW-1:HALF] * x_scale_q;
      d_t_lo_q  <= c_t_mag_q[HALF-1:0]  * y_scale_q;
      d_t_hi_q  <= c_t_mag_q[MW-1:HALF] * y_scale_q;
      d_b_lo_q  <= c_b_mag_q[HALF-1:0]  * y_scale_q;
      d_b_hi_q  <= c_b_mag_q[MW-1:HALF] * y_scale_q;
      d_x_neg_q <= c_x_neg_q;
      d_t_neg_q <= c_t_neg_q;
      d_b_neg_q <= c_b_neg_q;
      d_last_q  <= c_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: reduce the fraction to a sticky bit, clamp the integer part

  mmpd_pkg::scaled_t e_x_q, e_t_q, e_b_q;
  logic              e_x_neg_q, e_t_neg_q, e_b_neg_q;
  logic              e_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else if (ld_e) begin
      e_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_e && d_v_q) begin
      e_x_q     <= split_scale(d_x_lo_q, d_x_hi_q);
      e_t_q     <= split_scale(d_t_lo_q, d_t_hi_q);
      e_b_q     <= split_scale(d_b_lo_q, d_b_hi_q);
      e_x_neg_q <= d_x_neg_q;
      e_t_neg_q <= d_t_neg_q;
      e_b_neg_q <= d_b_neg_q;
      e_last_q  <= d_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: add the pixel base and saturate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (ld_o) begin
      o_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_o && e_v_q) begin
      column_x_o     <= to_pixel(e_x_q, e_x_neg_q, x_offset_q);
      y_top_o        <= to_pixel(e_t_q, e_t_neg_q, y_base_q);
      y_bottom_o     <= to_pixel(e_b_q, e_b_neg_q, y_base_q);
      final_column_o <= e_last_q;
    end
  end

endmodule

`default_nettype wire

// ===== test/column_check_pkg.sv =====
package column_check_pkg;
  import mmpd_pkg::*;

  localparam int CFG_W = (TIME_BITS > VALUE_BITS) ? TIME_BITS : VALUE_BITS;

  typedef logic [TIME_BITS-1:0]         stamp_t;
  typedef logic signed [VALUE_BITS-1:0] level_t;
  typedef logic signed [PIX_W-1:0]      pixel_t;
  typedef logic [CFG_W-1:0]             cfg_word_t;

  localparam stamp_t STAMP_MAX = '1;
  localparam level_t LEVEL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam level_t LEVEL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam pixel_t PIXEL_MAX = {1'b0, {(PIX_W-1){1'b1}}};
  localparam pixel_t PIXEL_MIN = {1'b1, {(PIX_W-1){1'b0}}};

  typedef struct packed {
    pixel_t x;
    pixel_t top;
    pixel_t bottom;
    logic   closes;
  } column_t;

  class column_scoreboard;
    // register copies
    stamp_t      origin;
    logic [31:0] step;
    logic [31:0] x_gain;
    logic [31:0] y_gain;
    pixel_t      x_left;
    pixel_t      y_mid;
    level_t      center;
    // bucket tracking
    stamp_t      bucket_end;
    level_t      peak;
    level_t      trough;
    bit          empty;
    bit          open;
    column_t     due[$];
    int          errors;

    function new();
      origin     = '0;
      step       = 32'd1;
      x_gain     = 32'd1 << SCALE_FRAC_BITS;
      y_gain     = 32'd1 << SCALE_FRAC_BITS;
      x_left     = '0;
      y_mid      = '0;
      center     = '0;
      bucket_end = '0;
      peak       = '0;
      trough     = '0;
      empty      = 1'b1;
      open       = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, cfg_word_t data);
      case (idx)
        CFG_TIME_ORIGIN:  origin = data[TIME_BITS-1:0];
        CFG_BUCKET_STEP:  step   = data[31:0];
        CFG_X_SCALE:      x_gain = data[31:0];
        CFG_X_OFFSET:     x_left = data[PIX_W-1:0];
        CFG_VALUE_CENTER: center = data[VALUE_BITS-1:0];
        CFG_Y_SCALE:      y_gain = data[31:0];
        CFG_Y_BASE:       y_mid  = data[PIX_W-1:0];
        default: ;
      endcase
    endfunction

    static function stamp_t advance(stamp_t a, logic [31:0] b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + b;
      return s[TIME_BITS] ? STAMP_MAX : s[TIME_BITS-1:0];
    endfunction

    // base +/- mag * gain / 2^F, truncated toward zero, saturated to a pixel
    function pixel_t project(logic [63:0] mag, bit neg, logic [31:0] gain, pixel_t base);
      logic [127:0] prod;
      logic [127:0] whole;
      bit           frac;
      longint       w;
      longint       acc;
      prod  = 128'(mag);
      prod  = prod * gain;
      whole = prod >> SCALE_FRAC_BITS;
      frac  = (prod & ((128'd1 << SCALE_FRAC_BITS) - 1)) != 0;
      if (whole > MAG_LIMIT) whole = MAG_LIMIT;
      w = whole[63:0];
      if (neg) begin
        acc = base - w;
        if (acc > 0 && frac) acc = acc - 1;
      end else begin
        acc = base + w;
        if (acc < 0 && frac) acc = acc + 1;
      end
      if (acc > 32767) acc = 32767;
      else if (acc < -32768) acc = -32768;
      return pixel_t'(acc);
    endfunction

    function pixel_t level_pixel(level_t v);
      longint d;
      d = longint'(center) - longint'(v);
      if (d < 0) return project(-d, 1'b1, y_gain, y_mid);
      return project(d, 1'b0, y_gain, y_mid);
    endfunction

    function void note_sample(stamp_t t, level_t v, bit last);
      column_t c;
      if (!open) begin
        bucket_end = advance(origin, step);
        empty      = 1'b1;
        open       = 1'b1;
      end
      if (empty) begin
        peak   = v;
        trough = v;
        empty  = 1'b0;
      end else begin
        if (v > peak) peak = v;
        if (v < trough) trough = v;
      end
      if (t < bucket_end && !last) return;

      if (t >= origin) c.x = project(64'(t - origin), 1'b0, x_gain, x_left);
      else c.x = project(64'(origin - t), 1'b1, x_gain, x_left);
      c.top    = level_pixel(peak);
      c.bottom = level_pixel(trough);
      c.closes = last;
      due = {due, c};

      // the end moves one step per column, however far the time jumped
      empty      = 1'b1;
      bucket_end = advance(bucket_end, step);
      if (last) open = 1'b0;
    endfunction

    function void check_column(pixel_t x, pixel_t top, pixel_t bottom, logic closes);
      column_t want;
      if (due.size() == 0) begin
        $error("column with no sample behind it: x %0d top %0d bottom %0d", x, top, bottom);
        errors++;
        return;
      end
      want = due.pop_front();
      if (x !== want.x) begin
        $error("column_x: expected %0d, got %0d", want.x, x);
        errors++;
      end
      if (top !== want.top) begin
        $error("y_top: expected %0d, got %0d", want.top, top);
        errors++;
      end
      if (bottom !== want.bottom) begin
        $error("y_bottom: expected %0d, got %0d", want.bottom, bottom);
        errors++;
      end
      if (closes !== want.closes) begin
        $error("final_column: expected %0d, got %0d", want.closes, closes);
        errors++;
      end
    endfunction

    function int outstanding();
      return due.size();
    endfunction
  endclass

endpackage

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mmpd_pkg::*;
  import column_check_pkg::*;

  logic      clk_i          = 1'b0;
  logic      rst_ni         = 1'b0;
  logic      in_valid_i     = 1'b0;
  stamp_t    sample_time_i  = '0;
  level_t    sample_value_i = '0;
  logic      series_end_i   = 1'b0;
  logic      out_ready_i    = 1'b0;
  logic      cfg_we_i       = 1'b0;
  cfg_idx_e  cfg_index_i    = CFG_TIME_ORIGIN;
  cfg_word_t cfg_data_i     = '0;

  logic   in_ready_o;
  logic   out_valid_o;
  pixel_t column_x_o;
  pixel_t y_top_o;
  pixel_t y_bottom_o;
  logic   final_column_o;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int phase_kind[6] = '{0, 1, 0, 2, 3, 0};

  column_scoreboard sb = new();

  always #4 clk_i = ~clk_i;

  minmax_plot_decimator u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sample_time_i,
    .sample_value_i,
    .series_end_i,
    .out_valid_o,
    .out_ready_i,
    .column_x_o,
    .y_top_o,
    .y_bottom_o,
    .final_column_o,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i
  );

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // signals settle by the falling edge; a transaction here completes at the next rise
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_column(column_x_o, y_top_o, y_bottom_o, final_column_o);
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic write_reg(cfg_idx_e idx, cfg_word_t data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic program_regs(stamp_t org, logic [31:0] stp, logic [31:0] xs, pixel_t xo,
                              level_t ctr, logic [31:0] ys, pixel_t yb);
    write_reg(CFG_TIME_ORIGIN, cfg_word_t'(org));
    write_reg(CFG_BUCKET_STEP, cfg_word_t'(stp));
    write_reg(CFG_X_SCALE, cfg_word_t'(xs));
    write_reg(CFG_X_OFFSET, cfg_word_t'(xo));
    write_reg(CFG_VALUE_CENTER, cfg_word_t'(ctr));
    write_reg(CFG_Y_SCALE, cfg_word_t'(ys));
    write_reg(CFG_Y_BASE, cfg_word_t'(yb));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic push_sample(stamp_t t, level_t v, bit last);
    bit taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_time_i  <= t;
    sample_value_i <= v;
    series_end_i   <= last;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end
    sb.note_sample(t, v, last);
    items_sent++;
  endtask

  // hold the input until every column is out and the pipeline is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic stamp_t clamp_stamp(longint s);
    if (s < 0) return '0;
    if (s > longint'(STAMP_MAX)) return STAMP_MAX;
    return stamp_t'(s);
  endfunction

  function automatic level_t pick_level(level_t around);
    case ($urandom_range(0, 3))
      0: return level_t'($urandom);
      1: return around + level_t'($urandom_range(0, 2000)) - level_t'(1000);
      2: return $urandom_range(0, 1) ? LEVEL_MAX : LEVEL_MIN;
      default: return around + level_t'($urandom_range(0, 64)) - level_t'(32);
    endcase
  endfunction

  // time starts near the origin and runs forward in roughly bucket-sized gaps; the last one closes
  task automatic send_series(int len);
    longint t;
    longint gap;
    level_t v;
    int     k;
    t = longint'(sb.origin);
    case ($urandom_range(0, 9))
      0: t = t - $urandom_range(1, 5000);
      default: t = t + $urandom_range(0, sb.step);
    endcase
    v = pick_level(sb.center);
    for (k = 0; k < len; k++) begin
      v = pick_level($urandom_range(0, 1) ? v : sb.center);
      push_sample(clamp_stamp(t), v, k == len - 1);
      case ($urandom_range(0, 19))
        0: gap = longint'(sb.step) * $urandom_range(2, 12);
        1: gap = 0;
        default: gap = longint'(sb.step) * $urandom_range(0, 200) / 100 + $urandom_range(0, 1);
      endcase
      t = t + gap;
    end
  endtask

  task automatic send_noise(int n);
    logic [63:0] r;
    int          k;
    for (k = 0; k < n; k++) begin
      r = {$urandom, $urandom};
      push_sample(r[TIME_BITS-1:0], level_t'($urandom), $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic random_setting(int kind);
    case (kind)
      0: program_regs(stamp_t'({$urandom_range(0, 65535), $urandom}), $urandom_range(1, 5000),
                      $urandom_range(0, 4096), pixel_t'(int'($urandom_range(0, 400)) - 200),
                      level_t'($urandom), $urandom_range(0, 16384),
                      pixel_t'(int'($urandom_range(0, 600)) - 300));
      1: program_regs('0, 32'd1, 32'd0, PIXEL_MIN, LEVEL_MIN, 32'hFFFF_FFFF, PIXEL_MAX);
      // bucket end saturates at the top of the time range
      2: program_regs(STAMP_MAX - stamp_t'($urandom_range(0, 1 << 20)), 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, PIXEL_MAX, LEVEL_MAX, 32'd0, PIXEL_MIN);
      default: program_regs(stamp_t'({$urandom, $urandom}), $urandom, $urandom,
                            pixel_t'($urandom), level_t'($urandom), $urandom,
                            pixel_t'($urandom));
    endcase
  endtask

  task automatic run_phase(int n);
    int stop_at;
    int pause_at;
    int len;
    bit paused;
    stop_at  = items_sent + n;
    pause_at = items_sent + $urandom_range(n / 4, 3 * n / 4);
    paused   = 1'b0;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(1, 40);
        if (len > stop_at - items_sent) len = stop_at - items_sent;
        send_series(len);
      end else begin
        send_noise($urandom_range(1, 5));
      end
      if (!paused && items_sent >= pause_at) begin
        settle();
        paused = 1'b1;
      end
    end
    settle();
  endtask

  initial begin
    int p;
    send_idle_pct = 35;
    recv_idle_pct = 87;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    program_regs(48'd1000, 32'd100, 32'h0001_0000, 16'sd0, 0, 32'h0001_0000, 16'sd0);
    push_sample(48'd1000, 5, 1'b0);
    push_sample(48'd1050, -7, 1'b0);
    push_sample(48'd1100, 3, 1'b0);
    push_sample(48'd1150, LEVEL_MAX, 1'b0);
    push_sample(48'd5000, LEVEL_MIN, 1'b0);
    push_sample(48'd1250, 0, 1'b0);
    push_sample(48'd1300, 1, 1'b0);
    push_sample(48'd500, 1, 1'b1);
    push_sample(48'd0, -1, 1'b1);
    push_sample(STAMP_MAX, 0, 1'b1);
    settle();

    // zero step with the end pinned at the top of the time range
    program_regs(STAMP_MAX, 32'd0, 32'hFFFF_FFFF, PIXEL_MIN, LEVEL_MAX, 32'hFFFF_FFFF,
                 PIXEL_MAX);
    push_sample(48'd0, LEVEL_MIN, 1'b0);
    push_sample(STAMP_MAX, LEVEL_MAX, 1'b0);
    push_sample(STAMP_MAX, 0, 1'b0);
    push_sample(48'd123, -5, 1'b1);
    settle();

    // half-pixel results on both sides of zero
    program_regs(48'd10, 32'd0, 32'h0000_8000, 16'sd0, 0, 32'h0000_8000, 16'sd0);
    push_sample(48'd10, 3, 1'b0);
    push_sample(48'd13, -3, 1'b0);
    push_sample(48'd7, 1, 1'b0);
    push_sample(48'd11, -1, 1'b1);
    settle();

    program_regs('0, 32'hFFFF_FFFF, 32'd0, PIXEL_MAX, LEVEL_MIN, 32'd1, PIXEL_MIN);
    push_sample(48'd0, LEVEL_MAX, 1'b0);
    push_sample(48'd5, LEVEL_MIN, 1'b1);
    settle();

    for (p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 87;
        recv_idle_pct = 35;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_setting(phase_kind[p]);
      run_phase(255);
    end

    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== minmax_plot_decimator.f =====
design/mmpd_pkg.sv
design/minmax_plot_decimator.sv
test/column_check_pkg.sv
test/tb_top.sv
